FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is applied.
`define RPB_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rpb assertion failed");

// Clocked check that also holds across reset.
`define RPB_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("rpb reset assertion failed");

`endif

FILE: design/rpb_pkg.sv
package rpb_pkg;

    typedef logic [7:0] t_chan;

    localparam t_chan CH_MAX    = 8'hFF;
    localparam t_chan CH_MIN    = 8'h00;
    localparam int    MUL_SHIFT = 8;
    localparam int    NUM_CH    = 4;
    localparam int    ALPHA_IDX = 3;

    typedef enum logic [2:0] {
        BM_ALPHA    = 3'd0,
        BM_REPLACE  = 3'd1,
        BM_ADD      = 3'd2,
        BM_SUBTRACT = 3'd3,
        BM_MULTIPLY = 3'd4,
        BM_LIGHTEN  = 3'd5,
        BM_DARKEN   = 3'd6,
        BM_SCREEN   = 3'd7
    } t_blend_mode;

    // (a*b) >> 8, so full scale times full scale gives 254
    function automatic t_chan ch_mul(input t_chan a, input t_chan b);
        logic [15:0] p;
        p = a * b;
        return p[MUL_SHIFT +: 8];
    endfunction

    // sum saturating at full scale
    function automatic t_chan ch_add(input t_chan a, input t_chan b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? CH_MAX : s[7:0];
    endfunction

    // difference clamped at zero
    function automatic t_chan ch_sub(input t_chan a, input t_chan b);
        return (a > b) ? t_chan'(a - b) : CH_MIN;
    endfunction

    // one output channel; is_alpha selects the alpha-channel variant
    function automatic t_chan blend_ch(input t_blend_mode mode, input t_chan dc,
                                       input t_chan sc, input t_chan sa,
                                       input logic is_alpha);
        t_chan src_term;
        t_chan r;
        src_term = is_alpha ? sa : ch_mul(sc, sa);
        unique case (mode)
            BM_ALPHA:    r = ch_add(ch_mul(dc, CH_MAX - sa), src_term);
            BM_REPLACE:  r = src_term;
            BM_ADD:      r = is_alpha ? dc : ch_add(dc, src_term);
            BM_SUBTRACT: r = is_alpha ? dc : ch_sub(dc, src_term);
            BM_MULTIPLY: r = ch_mul(sc, dc);
            BM_LIGHTEN:  r = (sc > dc) ? sc : dc;
            BM_DARKEN:   r = (sc < dc) ? sc : dc;
            BM_SCREEN:   r = ch_add(ch_mul(dc, CH_MAX - (is_alpha ? sa : sc)), src_term);
        endcase
        return r;
    endfunction

endpackage

FILE: design/rgba_pixel_blend_unit.sv
// RGBA8 pixel blend, eight modes selected by the blend_mode register.
// Pipeline: input register, blend logic with 8x8 multipliers per channel,
// result register.
// Throughput: one pixel per cycle while i_out_stall is low; the input register refills as the result register loads.
// Reset (synchronous, active low): both stages empty, blend_mode = replace.
module rgba_pixel_blend_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rpb_pkg::t_chan i_dst_r,
    input  rpb_pkg::t_chan i_dst_g,
    input  rpb_pkg::t_chan i_dst_b,
    input  rpb_pkg::t_chan i_dst_a,
    input  rpb_pkg::t_chan i_src_r,
    input  rpb_pkg::t_chan i_src_g,
    input  rpb_pkg::t_chan i_src_b,
    input  rpb_pkg::t_chan i_src_a,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rpb_pkg::t_chan o_out_r,
    output rpb_pkg::t_chan o_out_g,
    output rpb_pkg::t_chan o_out_b,
    output rpb_pkg::t_chan o_out_a
);
    import rpb_pkg::*;

    t_blend_mode r_mode;
    logic        r_in_valid;
    logic        r_out_valid;
    t_chan       r_dst [NUM_CH];
    t_chan       r_src [NUM_CH];
    t_chan       r_out [NUM_CH];
    t_chan       n_out [NUM_CH];
    logic        n_in_valid;
    logic        n_out_valid;
    logic        out_ready;
    logic        in_ready;
    logic        in_xfer;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= BM_REPLACE;
        end else if (i_cfg_we) begin
            r_mode <= t_blend_mode'(i_cfg_data);
        end
    end

    // pipeline flow control
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;
    assign in_xfer    = i_in_valid && in_ready;

    always_comb begin
        n_in_valid  = in_xfer ? 1'b1 : (out_ready ? 1'b0 : r_in_valid);
        n_out_valid = out_ready ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dst[0] <= i_dst_r;
            r_dst[1] <= i_dst_g;
            r_dst[2] <= i_dst_b;
            r_dst[3] <= i_dst_a;
            r_src[0] <= i_src_r;
            r_src[1] <= i_src_g;
            r_src[2] <= i_src_b;
            r_src[3] <= i_src_a;
        end
    end

    // per-channel blend; channel 3 is alpha
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            n_out[i] = blend_ch(r_mode, r_dst[i], r_src[i], r_src[ALPHA_IDX],
                                (i == ALPHA_IDX));
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_r     = r_out[0];
    assign o_out_g     = r_out[1];
    assign o_out_b     = r_out[2];
    assign o_out_a     = r_out[3];

endmodule

FILE: design/rpb_checker.sv
`include "assert_macros.svh"

module rpb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input rpb_pkg::t_chan o_out_r,
    input rpb_pkg::t_chan o_out_g,
    input rpb_pkg::t_chan o_out_b,
    input rpb_pkg::t_chan o_out_a
);
    logic [31:0] out_pix;

    // result pixel as one word, {a, b, g, r}
    assign out_pix = {o_out_a, o_out_b, o_out_g, o_out_r};

    // reset leaves both stages empty
    `RPB_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!o_out_valid && !o_in_stall))

    // a stalled result holds its pixel
    `RPB_ASSERT(a_hold_payload, (o_out_valid && i_out_stall) |=> $stable(out_pix))

    // input stalls only when the result stage is full and stalled
    `RPB_ASSERT(a_stall_cause, o_in_stall |-> (o_out_valid && i_out_stall))

    // an accepted pixel is followed by a valid result, which may be an older held pixel
    `RPB_ASSERT(a_latency, (i_in_valid && !o_in_stall) |-> ##2 o_out_valid)

endmodule

bind rgba_pixel_blend_unit rpb_checker u_rpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_r     (o_out_r),
    .o_out_g     (o_out_g),
    .o_out_b     (o_out_b),
    .o_out_a     (o_out_a)
);
